[hdl/lpfd_pkg.sv]
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

    // Widths of the frame fields.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_BYTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY    = 2'd2;

    // Configuration values after reset.
    localparam logic [BYTE_W-1:0] HEADER_BYTE_RESET = 8'h3A;
    localparam logic [BYTE_W-1:0] STOP_BYTE_RESET   = 8'h0A;
    localparam logic [LEN_W-1:0]  MAX_BODY_RESET    = 16'd511;

    // What a result beat reports.
    typedef enum logic [1:0] {
        KIND_BODY     = 2'd0,
        KIND_END_GOOD = 2'd1,
        KIND_END_BAD  = 2'd2,
        KIND_REJECT   = 2'd3
    } kind_t;

    // One result item.
    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic [LEN_W-1:0]  body_offset;
        logic [BYTE_W-1:0] data_byte;
        kind_t             kind;
    } result_t;

    // A result with its valid flag, passed from the parser to the output buffer.
    typedef struct packed {
        logic    valid;
        result_t data;
    } result_beat_t;

endpackage

[hdl/lpfd_in_stage.sv]
// Input register holding one received byte until the parser takes it.
module lpfd_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lpfd_pkg::BYTE_W-1:0] s_tdata,
    input  logic                      take,
    output logic                      byte_valid,
    output logic [lpfd_pkg::BYTE_W-1:0] byte_data
);
    import lpfd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              load;

    // The register may refill in the same cycle as it is drained.
    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

[hdl/lpfd_parser.sv]
// Frame parser: configuration registers, frame state and result decode.
module lpfd_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          consume,
    input  logic [lpfd_pkg::BYTE_W-1:0]     byte_data,
    output lpfd_pkg::result_beat_t        result
);
    import lpfd_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_LEN_LO = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] stop_reg;
    logic [LEN_W-1:0]  max_body_reg;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic [LEN_W-1:0]  remaining_reg;
    logic [LEN_W-1:0]  remaining_next;
    logic [LEN_W-1:0]  offset_reg;
    logic [LEN_W-1:0]  offset_next;
    logic [LEN_W-1:0]  full_length;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= HEADER_BYTE_RESET;
            stop_reg     <= STOP_BYTE_RESET;
            max_body_reg <= MAX_BODY_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HEADER_BYTE: header_reg   <= cfg_wdata[BYTE_W-1:0];
                CFG_STOP_BYTE:   stop_reg     <= cfg_wdata[BYTE_W-1:0];
                CFG_MAX_BODY:    max_body_reg <= cfg_wdata[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Length as completed by the low length byte.
    assign full_length = {length_reg[LEN_W-1:BYTE_W], byte_data};

    // Next state and at most one result for the byte being consumed.
    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        offset_next    = offset_reg;
        result.valid             = 1'b0;
        result.data.kind         = KIND_BODY;
        result.data.data_byte    = byte_data;
        result.data.body_offset  = '0;
        result.data.frame_length = length_reg;
        if (consume)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_data == header_reg)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    length_next = {byte_data, {BYTE_W{1'b0}}};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = full_length;
                    offset_next = '0;
                    if (full_length > max_body_reg)
                    begin
                        phase_next               = PH_HUNT;
                        remaining_next           = '0;
                        result.valid             = 1'b1;
                        result.data.kind         = KIND_REJECT;
                        result.data.frame_length = full_length;
                    end
                    else
                    begin
                        remaining_next = full_length;
                        phase_next     = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    result.valid = 1'b1;
                    if (remaining_reg == '0)
                    begin
                        phase_next       = PH_HUNT;
                        offset_next      = '0;
                        result.data.kind = (byte_data == stop_reg) ? KIND_END_GOOD
                                                                   : KIND_END_BAD;
                    end
                    else
                    begin
                        result.data.body_offset = offset_reg;
                        remaining_next          = remaining_reg - 1'b1;
                        offset_next             = offset_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            length_reg    <= '0;
            remaining_reg <= '0;
            offset_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            offset_reg    <= offset_next;
        end
    end

    // While hunting no byte gives a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (consume && phase_reg == PH_HUNT) |-> !result.valid)
        else $error("result produced while hunting for a header");

    // A body byte always lies inside the announced body.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.kind == KIND_BODY)
            |-> (result.data.body_offset < result.data.frame_length))
        else $error("body offset beyond frame length");

endmodule

[hdl/lpfd_out_buf.sv]
// Two-entry output buffer that decouples the parser from downstream stalls.
module lpfd_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lpfd_pkg::result_beat_t result,
    output logic                   full,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output lpfd_pkg::result_t      head
);
    import lpfd_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign full     = (count_reg == 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign push     = result.valid;
    assign pop      = m_tvalid && m_tready;
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= result.data;
        end
    end

    // The parser never pushes into a full buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && count_reg == 2'd2))
        else $error("result pushed into full output buffer");

    // A pop without a push frees exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("output buffer count wrong after pop");

endmodule

[hdl/length_prefixed_frame_deframer_unit.sv]
// Top level of the length-prefixed frame deframer.
//
// Received serial bytes enter on the s_ channel, one byte per beat. The block
// hunts for the header byte, reads a two-byte big-endian body length, then
// passes each body byte out on the m_ channel with its offset, and finally
// reports a good or bad frame end from the byte after the body. A length
// above max_body_length is reported as rejected. Bytes outside a frame give
// no result beat. The user must write header_byte (index 0), stop_byte (index
// 1) and max_body_length (index 2) on the configuration port only while the
// block is idle; the block does not enforce this. Throughput is one byte per
// cycle while the output buffer has room. A result goes from the input
// register through the parser into the two-entry output buffer. Reset loads
// the default configuration, returns the parser to header hunt and empties
// both buffers. When the receiver stalls, the output buffer absorbs two
// results, then the input register holds and s_tready drops.
module length_prefixed_frame_deframer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Received bytes.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    // Results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,   // [7:0] data_byte,
                                                       // [23:8] body_offset,
                                                       // [39:24] frame_length
    output logic [1:0]                      m_tuser    // [1:0] kind
);
    import lpfd_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              take;
    logic              out_full;
    result_beat_t      result;
    result_t           head;

    // A byte is parsed whenever the output buffer has room for its result.
    assign take = byte_valid && !out_full;

    lpfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    lpfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .consume   (take),
        .byte_data (byte_data),
        .result    (result)
    );

    lpfd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .full     (out_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // Pack the result fields onto the stream.
    assign m_tdata = {head.frame_length, head.body_offset, head.data_byte};
    assign m_tuser = head.kind;

endmodule

[tb/sv/tb_length_prefixed_frame_deframer_unit.sv]
// Self-checking testbench for the length-prefixed frame deframer, with directed and random frames.
module tb_length_prefixed_frame_deframer_unit;

    import lpfd_pkg::*;

    // Register index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Cycles a byte may still be in flight after the last result has come.
    localparam int unsigned SETTLE_CYCLES = 6;
    // Bound on the wait for outstanding results.
    localparam int unsigned DRAIN_LIMIT = 5000;
    // Beats sent in each random configuration phase.
    localparam int unsigned PHASE_BEATS = 400;
    localparam int unsigned RANDOM_PHASES = 5;

    // Parser position within a frame.
    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_BODY   = 2'd3
    } parse_phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;   // [7:0] data_byte, [23:8] body_offset, [39:24] frame_length
    logic [1:0]            m_tuser;   // [1:0] kind

    // Mirror of the configuration registers.
    logic [BYTE_W-1:0] header_cfg = HEADER_BYTE_RESET;
    logic [BYTE_W-1:0] stop_cfg   = STOP_BYTE_RESET;
    logic [LEN_W-1:0]  max_len_cfg = MAX_BODY_RESET;

    // Mirror of the parser state.
    parse_phase_t     parse_phase = PH_HUNT;
    logic [LEN_W-1:0] frame_len = '0;
    logic [LEN_W-1:0] body_left = '0;
    logic [LEN_W-1:0] body_pos = '0;

    // Results still to come from the block, oldest first.
    result_t pending_results[$];

    int unsigned error_count = 0;
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;

    length_prefixed_frame_deframer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on the run time.
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // Push one result onto the list of pending results.
    task automatic push_result(input kind_t kind, input logic [7:0] rx,
                               input logic [LEN_W-1:0] offset);
        result_t res;
        res.kind         = kind;
        res.data_byte    = rx;
        res.body_offset  = offset;
        res.frame_length = frame_len;
        pending_results.push_back(res);
    endtask

    // Advance the parser mirror by one accepted byte.
    task automatic deframe_byte(input logic [7:0] rx);
        case (parse_phase)
            PH_HUNT:
            begin
                if (rx == header_cfg)
                    parse_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_len   = {rx, 8'h00};
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_len[7:0] = rx;
                body_pos = '0;
                if (frame_len > max_len_cfg)
                begin
                    parse_phase = PH_HUNT;
                    body_left   = '0;
                    push_result(KIND_REJECT, rx, '0);
                end
                else
                begin
                    body_left   = frame_len;
                    parse_phase = PH_BODY;
                end
            end
            default:
            begin
                if (body_left == 0)
                begin
                    parse_phase = PH_HUNT;
                    body_pos    = '0;
                    push_result((rx == stop_cfg) ? KIND_END_GOOD : KIND_END_BAD, rx, '0);
                end
                else
                begin
                    push_result(KIND_BODY, rx, body_pos);
                    body_left = body_left - 1'b1;
                    body_pos  = body_pos + 1'b1;
                end
            end
        endcase
    endtask

    // Send one byte beat, with random gaps between bursts.
    // Entered and left just after a falling edge.
    task automatic send_byte(input logic [7:0] rx);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        deframe_byte(rx);
        beats_sent = beats_sent + 1;
        @(negedge clk);
    endtask

    // Send a frame header, its length and, if accepted, a random body and the tail byte.
    task automatic send_frame(input logic [7:0] hdr, input logic [LEN_W-1:0] len,
                              input logic [7:0] tail);
        send_byte(hdr);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len <= max_len_cfg)
        begin
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            send_byte(tail);
        end
    endtask

    // Hold the sender until every pending result has come, then let the pipeline settle.
    task automatic wait_results_drained();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited = waited + 1;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            error_count = error_count + 1;
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one configuration register while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_results_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_HEADER_BYTE: header_cfg = val[7:0];
            CFG_STOP_BYTE:   stop_cfg = val[7:0];
            CFG_MAX_BODY:    max_len_cfg = val;
            default:         ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Frames under the reset configuration.
    task automatic test_default_frames();
        // Header value used as body data, then a good end.
        send_byte(8'h3A);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h3A);
        send_byte(8'hFF);
        send_byte(8'h0A);
        // Empty body with a bad stop byte equal to the header; the following
        // bytes must be dropped rather than parsed as a length.
        send_frame(8'h3A, 16'd0, 8'h3A);
        send_byte(8'h00);
        send_byte(8'h0A);
        // One past the reset maximum is rejected.
        send_frame(8'h3A, 16'd512, 8'h00);
    endtask

    // Length limits and register extremes.
    task automatic test_length_limits();
        write_reg(CFG_HEADER_BYTE, 16'h0000);
        write_reg(CFG_STOP_BYTE, 16'h00FF);
        write_reg(CFG_MAX_BODY, 16'd1);
        // A length equal to the maximum is accepted, one more is not.
        send_frame(8'h00, 16'd1, 8'hFF);
        send_frame(8'h00, 16'd2, 8'hFF);
        // An empty body is accepted when the maximum is zero.
        write_reg(CFG_MAX_BODY, 16'd0);
        send_frame(8'h00, 16'd0, 8'hFF);
        write_reg(CFG_HEADER_BYTE, 16'h00FF);
        write_reg(CFG_STOP_BYTE, 16'h0000);
        write_reg(CFG_MAX_BODY, 16'hFFFE);
        send_frame(8'hFF, 16'hFFFF, 8'h00);
        // A write to the unused index must change nothing.
        write_reg(CFG_UNUSED, 16'h0000);
        send_frame(8'hFF, 16'd3, 8'h00);
    endtask

    // Random configurations, each followed by mostly well-formed random frames.
    task automatic test_random_traffic();
        int unsigned phase_idx;
        int unsigned phase_end;
        int unsigned pick;
        int unsigned cap;
        logic [LEN_W-1:0] len;
        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++)
        begin
            // The drain inside each write also pauses the sender until all results are in.
            write_reg(CFG_HEADER_BYTE, 16'($urandom_range(0, 255)));
            write_reg(CFG_STOP_BYTE, 16'($urandom_range(0, 255)));
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_MAX_BODY, 16'($urandom_range(0, 40)));
                1:       write_reg(CFG_MAX_BODY, 16'hFFFF);
                2:       write_reg(CFG_MAX_BODY, 16'($urandom_range(0, 300)));
                default: write_reg(CFG_MAX_BODY, 16'($urandom_range(300, 65535)));
            endcase
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                cap  = ($urandom_range(0, 9) == 0) ? 300 : 24;
                if (cap > max_len_cfg)
                    cap = 32'(max_len_cfg);
                len = 16'($urandom_range(0, cap));
                if (pick < 60)
                    send_frame(header_cfg, len, stop_cfg);
                else if (pick < 72)
                    send_frame(header_cfg, len, stop_cfg ^ 8'($urandom_range(1, 255)));
                else if (pick < 87 && max_len_cfg != 16'hFFFF)
                    send_frame(header_cfg, 16'($urandom_range(max_len_cfg + 1, 65535)), 8'h00);
                else if (pick < 92)
                begin
                    // Frame cut short after its header.
                    send_byte(header_cfg);
                    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Receiver readiness, switching among four patterns after each randomly drawn run.
    int unsigned ready_mode = 0;
    int unsigned ready_left = 0;
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(50, 400);
        end
        else
            ready_left = ready_left - 1;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((ready_left % 7) < 3);
            default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Report one field that differs from its expected value.
    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count = error_count + 1;
        end
    endtask

    // Compare each result beat with the oldest pending result.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (m_tvalid && m_tready)
        begin
            got = result_t'({m_tdata, m_tuser});
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d data %0d",
                         $time, got.kind, got.data_byte);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(got.kind));
                check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
                check_field("body_offset", 32'(want.body_offset), 32'(got.body_offset));
                check_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
            end
        end
    end

    // Reset, then run the tests in turn.
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_frames();
        test_length_limits();
        test_random_traffic();
        wait_results_drained();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
